### rtl/wrp_pkg.sv
// Shared types and constants of the windowed rate policer.
// Depends on nothing; every other file of the block uses it.
package wrp_pkg;

    // Bucket table geometry: the slot field indexes the table directly.
    localparam int SLOT_W    = 7;
    localparam int NUM_FLOWS = 2 ** SLOT_W;

    // Field widths.
    localparam int BYTES_W = 16;
    localparam int TS_W    = 64;
    localparam int RATE_W  = 32;
    localparam int WIN_W   = 32;

    // Window register reset value, in nanoseconds.
    localparam logic [WIN_W-1:0] WINDOW_RESET = 32'd1_000_000_000;

    // Scale of the random early drop, and the width of a value below it.
    localparam int               PCT_W     = 7;
    localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

    // Timestamp residue unit: one nibble per cycle, most significant first.
    localparam int MOD_NIBBLES = TS_W / 4;
    localparam int MOD_CNT_W   = $clog2(MOD_NIBBLES);

    // Refill divider: two quotient bits per cycle.
    localparam int QUO_W      = RATE_W;
    localparam int DIV_CYCLES = QUO_W / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    // Verdict reason codes.
    typedef enum logic [2:0] {
        RSN_UNLIMITED   = 3'd0,
        RSN_NEW_FLOW    = 3'd1,
        RSN_RESTART     = 3'd2,
        RSN_IN_BUDGET   = 3'd3,
        RSN_RANDOM_DROP = 3'd4,
        RSN_NO_HEADROOM = 3'd5
    } t_reason;

    // Which decision the datapath closes an item with.
    typedef enum logic [1:0] {
        FIN_UNLIM,
        FIN_NEW,
        FIN_RESTART,
        FIN_BUDGET
    } t_fin;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_CLASS,
        S_MUL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_REFILL,
        S_RISK,
        S_JUDGE,
        S_COMMIT
    } t_state;

    // One bucket entry.
    typedef struct packed {
        logic [TS_W-1:0]   start;
        logic [TS_W-1:0]   last;
        logic [RATE_W-1:0] head;
        logic [RATE_W-1:0] sent;
    } t_entry;

    // Controller to datapath commands.
    typedef struct packed {
        logic idle;
        logic read;
        logic cmp;
        logic fin_en;
        t_fin fin;
        logic load_prod;
        logic div_start;
        logic refill;
        logic risk;
        logic commit;
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic in_fire;
        logic rate_zero;
        logic bkt_valid;
        logic restart;
        logic gap_ge;
        logic div_busy;
        logic mod_done;
        logic out_free;
    } t_dp_sts;

endpackage

### rtl/wrp_if.sv
// Channel interfaces of the windowed rate policer: packets, window register, verdicts.
// Depends on wrp_pkg for the field widths.
interface wrp_in_if;
    logic                          valid;
    logic                          ready;
    logic [wrp_pkg::SLOT_W-1:0]    flow_slot;
    logic [wrp_pkg::BYTES_W-1:0]   frame_bytes;
    logic [wrp_pkg::TS_W-1:0]      now_ns;
    logic [wrp_pkg::RATE_W-1:0]    flow_rate;

    modport source (output valid, flow_slot, frame_bytes, now_ns, flow_rate, input ready);
    modport sink   (input valid, flow_slot, frame_bytes, now_ns, flow_rate, output ready);
endinterface

interface wrp_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [wrp_pkg::WIN_W-1:0]  window_ns;

    modport source (output valid, window_ns, input ready);
    modport sink   (input valid, window_ns, output ready);
endinterface

interface wrp_out_if;
    logic       valid;
    logic       ready;
    logic       pass_packet;
    logic [2:0] verdict_reason;

    modport source (output valid, pass_packet, verdict_reason, input ready);
    modport sink   (input valid, pass_packet, verdict_reason, output ready);
endinterface

### rtl/wrp_div.sv
// Radix-4 restoring divider for the refill amount: quotient of a 64-bit
// dividend by a 32-bit divisor, where the quotient is known to fit 32 bits.
// Depends on wrp_pkg.
module wrp_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [2*wrp_pkg::QUO_W-1:0] i_dividend,
    input  logic [wrp_pkg::WIN_W-1:0]   i_divisor,
    output logic                        o_busy,
    output logic [wrp_pkg::QUO_W-1:0]   o_quotient
);
    import wrp_pkg::*;

    logic [QUO_W-1:0]     r_rem;
    logic [QUO_W-1:0]     r_lo;
    logic [QUO_W-1:0]     r_quo;
    logic [WIN_W-1:0]     r_div;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;

    logic [QUO_W:0] n_step1;
    logic [QUO_W:0] n_step2;

    // One restoring step: shift in a bit, subtract when the divisor fits.
    // The result carries the quotient bit on top of the new remainder.
    function automatic logic [QUO_W:0] div_step(input logic [QUO_W-1:0] rem,
                                                input logic             bit_in,
                                                input logic [WIN_W-1:0] dvs);
        logic [QUO_W:0] t;
        logic [QUO_W:0] d;
        t = {rem, bit_in};
        d = {1'b0, dvs};
        if (t >= d) begin
            div_step = {1'b1, QUO_W'(t - d)};
        end else begin
            div_step = {1'b0, t[QUO_W-1:0]};
        end
    endfunction

    // Two dependent steps per cycle.
    always_comb begin
        n_step1 = div_step(r_rem, r_lo[QUO_W-1], r_div);
        n_step2 = div_step(n_step1[QUO_W-1:0], r_lo[QUO_W-2], r_div);
    end

    // Control: busy from a start until all quotient bits are shifted in.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[2*QUO_W-1:QUO_W];
            r_lo  <= i_dividend[QUO_W-1:0];
            r_div <= i_divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_step2[QUO_W-1:0];
            r_lo  <= {r_lo[QUO_W-3:0], 2'b00};
            r_quo <= {r_quo[QUO_W-3:0], n_step1[QUO_W], n_step2[QUO_W]};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

### rtl/wrp_dp.sv
// Datapath of the windowed rate policer: bucket table, window register,
// refill arithmetic, timestamp residue, verdict and output register.
// Depends on wrp_pkg, the channel interfaces and wrp_div.
module wrp_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    wrp_in_if.sink            i_pkt,
    wrp_cfg_if.sink           i_cfg,
    wrp_out_if.source         o_verdict,
    input  wrp_pkg::t_dp_cmd  i_cmd,
    output wrp_pkg::t_dp_sts  o_sts
);
    import wrp_pkg::*;

    // Bucket table and its valid bits.
    t_entry                r_mem [NUM_FLOWS];
    logic [NUM_FLOWS-1:0]  r_valid;

    // Window length register.
    logic [WIN_W-1:0]      r_window;

    // Captured packet.
    logic [SLOT_W-1:0]     r_slot;
    logic [BYTES_W-1:0]    r_bytes;
    logic [TS_W-1:0]       r_now;
    logic [RATE_W-1:0]     r_rate;

    // Table read and comparison results.
    t_entry                r_rd_entry;
    logic                  r_rd_valid;
    logic                  r_restart;
    logic                  r_gap_ge;
    logic [WIN_W-1:0]      r_gap_lo;

    // Refill and early drop operands.
    logic [2*QUO_W-1:0]    r_prod;
    logic [RATE_W-1:0]     r_hr;
    logic [RATE_W+8-1:0]   r_rhs;

    // Timestamp residue unit.
    logic [PCT_W-1:0]      r_mod;
    logic [MOD_CNT_W-1:0]  r_mod_cnt;
    logic                  r_mod_busy;

    // Pending decision.
    logic                  r_res_pass;
    t_reason               r_res_reason;
    logic                  r_wr;
    t_entry                r_wr_entry;

    // Output register.
    logic                  r_out_valid;
    logic                  r_out_pass;
    t_reason               r_out_reason;

    logic                  in_fire;
    logic                  out_free;
    logic [TS_W-1:0]       elapsed;
    logic [TS_W-1:0]       gap;
    logic [QUO_W-1:0]      quotient;
    logic                  div_busy;
    logic [RATE_W-1:0]     burst;
    logic [RATE_W:0]       hr_sum;
    logic [RATE_W:0]       sent_p1;
    logic [RATE_W+8-1:0]   lhs;
    logic [RATE_W:0]       sent_sum;
    logic [RATE_W-1:0]     sent_sat;
    logic [3:0]            nibble;
    logic [PCT_W-1:0]      mod_next;

    // Handshakes.
    assign i_pkt.ready = i_cmd.idle;
    assign i_cfg.ready = 1'b1;
    assign in_fire     = i_pkt.valid && i_pkt.ready;
    assign out_free    = !r_out_valid || o_verdict.ready;

    // Window register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (i_cfg.valid) begin
            r_window <= i_cfg.window_ns;
        end
    end

    // Packet capture.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_slot  <= i_pkt.flow_slot;
            r_bytes <= i_pkt.frame_bytes;
            r_now   <= i_pkt.now_ns;
            r_rate  <= i_pkt.flow_rate;
        end
    end

    // Bucket table: one registered read, one write at commit.
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd_entry <= r_mem[r_slot];
        end
        if (i_cmd.commit && r_wr) begin
            r_mem[r_slot] <= r_wr_entry;
        end
    end

    // Valid bits, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.commit && r_wr) begin
            r_valid[r_slot] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd_valid <= r_valid[r_slot];
        end
    end

    // Elapsed time and gap against the window.
    assign elapsed = r_now - r_rd_entry.start;
    assign gap     = r_now - r_rd_entry.last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            r_restart <= elapsed >= TS_W'(r_window);
            r_gap_ge  <= gap >= TS_W'(r_window);
            r_gap_lo  <= gap[WIN_W-1:0];
        end
    end

    // Refill product; the gap is below the window here, so it fits 32 bits.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_prod) begin
            r_prod <= (2*QUO_W)'(r_rate) * (2*QUO_W)'(r_gap_lo);
        end
    end

    wrp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_window),
        .o_busy     (div_busy),
        .o_quotient (quotient)
    );

    // Refilled headroom, capped at the rate.
    assign burst  = r_gap_ge ? r_rate : quotient;
    assign hr_sum = {1'b0, r_rd_entry.head} + {1'b0, burst};

    always_ff @(posedge i_clk) begin
        if (i_cmd.refill) begin
            r_hr <= (hr_sum > {1'b0, r_rate}) ? r_rate : hr_sum[RATE_W-1:0];
        end
    end

    // Early drop test without a division: residue > floor(100*rate/(sent+1))
    // holds exactly when 100*rate < residue*(sent+1).
    assign sent_p1 = {1'b0, r_rd_entry.sent} + (RATE_W+1)'(1);
    assign lhs     = (RATE_W+8)'(r_rate) * (RATE_W+8)'(PCT_SCALE);

    always_ff @(posedge i_clk) begin
        if (i_cmd.risk) begin
            r_rhs <= (RATE_W+8)'(r_mod) * (RATE_W+8)'(sent_p1);
        end
    end

    // Timestamp modulo 100, one nibble per cycle from the top.
    function automatic logic [PCT_W-1:0] mod_step(input logic [PCT_W-1:0] r,
                                                  input logic             b);
        logic [PCT_W:0] t;
        t = {r, b};
        if (t >= {1'b0, PCT_SCALE}) begin
            mod_step = PCT_W'(t - {1'b0, PCT_SCALE});
        end else begin
            mod_step = t[PCT_W-1:0];
        end
    endfunction

    assign nibble = r_now[{~r_mod_cnt, 2'b00} +: 4];

    always_comb begin
        mod_next = r_mod;
        for (int k = 3; k >= 0; k--) begin
            mod_next = mod_step(mod_next, nibble[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod_busy <= 1'b0;
            r_mod_cnt  <= '0;
        end else if (in_fire) begin
            r_mod_busy <= 1'b1;
            r_mod_cnt  <= '0;
        end else if (r_mod_busy) begin
            r_mod_cnt <= r_mod_cnt + 1'b1;
            if (r_mod_cnt == MOD_CNT_W'(MOD_NIBBLES - 1)) begin
                r_mod_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_mod <= '0;
        end else if (r_mod_busy) begin
            r_mod <= mod_next;
        end
    end

    // Saturating sent counter.
    assign sent_sum = {1'b0, r_rd_entry.sent} + (RATE_W+1)'(r_bytes);
    assign sent_sat = sent_sum[RATE_W] ? '1 : sent_sum[RATE_W-1:0];

    // Decision and the entry to write back.
    always_ff @(posedge i_clk) begin
        if (i_cmd.fin_en) begin
            unique case (i_cmd.fin)
                FIN_UNLIM: begin
                    r_res_pass   <= 1'b1;
                    r_res_reason <= RSN_UNLIMITED;
                    r_wr         <= 1'b0;
                    r_wr_entry   <= r_rd_entry;
                end
                FIN_NEW: begin
                    r_res_pass       <= 1'b1;
                    r_res_reason     <= RSN_NEW_FLOW;
                    r_wr             <= 1'b1;
                    r_wr_entry.start <= r_now;
                    r_wr_entry.last  <= r_now;
                    r_wr_entry.head  <= r_rate;
                    r_wr_entry.sent  <= '0;
                end
                FIN_RESTART: begin
                    r_res_pass       <= 1'b1;
                    r_res_reason     <= RSN_RESTART;
                    r_wr             <= 1'b1;
                    r_wr_entry.start <= r_now;
                    r_wr_entry.last  <= r_now;
                    r_wr_entry.head  <= (r_rate > RATE_W'(r_bytes)) ?
                                        r_rate - RATE_W'(r_bytes) : '0;
                    r_wr_entry.sent  <= RATE_W'(r_bytes);
                end
                FIN_BUDGET: begin
                    r_wr             <= 1'b1;
                    r_wr_entry.start <= r_rd_entry.start;
                    r_wr_entry.last  <= r_now;
                    if (r_hr > RATE_W'(r_bytes)) begin
                        if (lhs < r_rhs) begin
                            r_res_pass      <= 1'b0;
                            r_res_reason    <= RSN_RANDOM_DROP;
                            r_wr_entry.head <= r_hr;
                            r_wr_entry.sent <= r_rd_entry.sent;
                        end else begin
                            r_res_pass      <= 1'b1;
                            r_res_reason    <= RSN_IN_BUDGET;
                            r_wr_entry.head <= r_hr - RATE_W'(r_bytes);
                            r_wr_entry.sent <= sent_sat;
                        end
                    end else begin
                        r_res_pass      <= 1'b0;
                        r_res_reason    <= RSN_NO_HEADROOM;
                        r_wr_entry.head <= r_hr;
                        r_wr_entry.sent <= r_rd_entry.sent;
                    end
                end
                default: begin
                    r_wr <= 1'b0;
                end
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (o_verdict.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_pass   <= r_res_pass;
            r_out_reason <= r_res_reason;
        end
    end

    assign o_verdict.valid          = r_out_valid;
    assign o_verdict.pass_packet    = r_out_pass;
    assign o_verdict.verdict_reason = r_out_reason;

    // Status to the controller.
    always_comb begin
        o_sts.in_fire   = in_fire;
        o_sts.rate_zero = (r_rate == '0);
        o_sts.bkt_valid = r_rd_valid;
        o_sts.restart   = r_restart;
        o_sts.gap_ge    = r_gap_ge;
        o_sts.div_busy  = div_busy;
        o_sts.mod_done  = !r_mod_busy;
        o_sts.out_free  = out_free;
    end

    // A verdict is only loaded into a free output register.
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_valid || o_verdict.ready))
        else $error("verdict committed over a pending result");

    // Every commit presents a verdict in the next cycle.
    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("committed verdict not presented");

    // The divider is never restarted mid-division.
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> !div_busy)
        else $error("divider started while busy");

    // Refilled headroom never exceeds the committed rate.
    a_hr_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.refill |=> (r_hr <= r_rate))
        else $error("headroom above rate after refill");

endmodule

### rtl/wrp_ctrl.sv
// Controller of the windowed rate policer: sequences one packet at a time
// through the datapath by command and status structs.
// Depends on wrp_pkg.
module wrp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wrp_pkg::t_dp_sts  i_sts,
    output wrp_pkg::t_dp_cmd  o_cmd
);
    import wrp_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_sts.in_fire) begin
                    n_state = S_READ;
                end
            end
            S_READ:  n_state = S_CMP;
            S_CMP:   n_state = S_CLASS;
            S_CLASS: begin
                priority if (i_sts.rate_zero || !i_sts.bkt_valid || i_sts.restart) begin
                    n_state = S_COMMIT;
                end else if (i_sts.gap_ge) begin
                    n_state = S_REFILL;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL:    n_state = S_DIV_GO;
            S_DIV_GO: n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (!i_sts.div_busy) begin
                    n_state = S_REFILL;
                end
            end
            S_REFILL: n_state = S_RISK;
            S_RISK: begin
                if (i_sts.mod_done) begin
                    n_state = S_JUDGE;
                end
            end
            S_JUDGE: n_state = S_COMMIT;
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE:  o_cmd.idle = 1'b1;
            S_READ:  o_cmd.read = 1'b1;
            S_CMP:   o_cmd.cmp  = 1'b1;
            S_CLASS: begin
                priority if (i_sts.rate_zero) begin
                    o_cmd.fin_en = 1'b1;
                    o_cmd.fin    = FIN_UNLIM;
                end else if (!i_sts.bkt_valid) begin
                    o_cmd.fin_en = 1'b1;
                    o_cmd.fin    = FIN_NEW;
                end else if (i_sts.restart) begin
                    o_cmd.fin_en = 1'b1;
                    o_cmd.fin    = FIN_RESTART;
                end else begin
                    o_cmd.fin_en = 1'b0;
                end
            end
            S_MUL:      o_cmd.load_prod = 1'b1;
            S_DIV_GO:   o_cmd.div_start = 1'b1;
            S_DIV_WAIT: o_cmd.idle      = 1'b0;
            S_REFILL:   o_cmd.refill    = 1'b1;
            S_RISK:     o_cmd.risk      = 1'b1;
            S_JUDGE: begin
                o_cmd.fin_en = 1'b1;
                o_cmd.fin    = FIN_BUDGET;
            end
            S_COMMIT: o_cmd.commit = i_sts.out_free;
            default:  o_cmd = '0;
        endcase
    end

endmodule

### rtl/windowed_rate_policer_top.sv
// Unlimited, new and restarted flows go from packet transaction to verdict with no refill;
// a full refill is paced by the timestamp residue, and a refill through the radix-4 divider
// is the longest path. One packet is in flight: the next is taken only once its verdict
// is committed, and a commit waits for a free output register.
// Reset: synchronous active-low; clears all bucket valid bits at once and loads
// the window register with 1000000000 ns; bucket contents need no clearing.
module windowed_rate_policer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wrp_in_if.sink     i_pkt,
    wrp_cfg_if.sink    i_cfg,
    wrp_out_if.source  o_verdict
);
    import wrp_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer.
    wrp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Bucket table and arithmetic.
    wrp_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pkt     (i_pkt),
        .i_cfg     (i_cfg),
        .o_verdict (o_verdict),
        .i_cmd     (cmd),
        .o_sts     (sts)
    );

endmodule

### tb/sv/tb.sv
// Self-checking testbench for windowed_rate_policer_top: per-flow packet policing.
// Depends on wrp_pkg for field widths and reason codes, and on the channel interfaces in wrp_if.
`timescale 1ns / 100ps

module tb;
    import wrp_pkg::*;

    // Run limits and traffic shape.
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PHASES        = 6;
    localparam int PHASE_PKTS    = 265;
    localparam int HOT_FLOWS     = 8;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 40;

    // One packet as the block sees it.
    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [BYTES_W-1:0] bytes;
        logic [TS_W-1:0]    now;
        logic [RATE_W-1:0]  rate;
    } t_pkt;

    // One verdict.
    typedef struct packed {
        logic    pass;
        t_reason why;
    } t_verdict;

    // One step of the directed script: a packet, or a new window length carried in rate.
    typedef enum logic {
        STEP_PACKET,
        STEP_WINDOW
    } t_step_kind;

    typedef struct packed {
        t_step_kind         kind;
        logic [SLOT_W-1:0]  slot;
        logic [BYTES_W-1:0] bytes;
        logic [TS_W-1:0]    now;
        logic [RATE_W-1:0]  rate;
        logic               typed;
        logic               pass;
        t_reason            why;
    } t_step;

    // Directed script. Verdicts are typed in where they follow at a glance; the
    // remaining rows are checked against the bucket predictor.
    localparam int SCRIPT_LEN = 24;
    localparam t_step POLICE_SCRIPT [SCRIPT_LEN] = '{
        // Unlimited rate on a fresh slot, then a new flow and an in-budget packet.
        '{STEP_PACKET, 7'd0,   16'd64,    64'd0,  32'd0,    1'b1, 1'b1, RSN_UNLIMITED},
        '{STEP_PACKET, 7'd0,   16'd100,   64'd0,  32'd1000, 1'b1, 1'b1, RSN_NEW_FLOW},
        '{STEP_PACKET, 7'd0,   16'd200,   64'd10, 32'd1000, 1'b0, 1'b0, RSN_UNLIMITED},
        // Largest frame against 800 bytes of headroom.
        '{STEP_PACKET, 7'd0,   16'hFFFF,  64'd20, 32'd1000, 1'b1, 1'b0, RSN_NO_HEADROOM},
        // Window end: headroom saturates at zero and sent takes the whole frame.
        '{STEP_PACKET, 7'd0,   16'hFFFF,  64'd1_000_000_000, 32'd1000,
          1'b1, 1'b1, RSN_RESTART},
        // Half a window refills 500 bytes; residue 99 beats a ceiling of 1.
        '{STEP_PACKET, 7'd0,   16'd10,    64'd1_500_000_099, 32'd1000,
          1'b1, 1'b0, RSN_RANDOM_DROP},
        '{STEP_PACKET, 7'd0,   16'd10,    64'd1_500_000_101, 32'd1000,
          1'b0, 1'b0, RSN_UNLIMITED},
        // Time stepping back inside the window makes a huge gap and a full refill.
        '{STEP_PACKET, 7'd3,   16'd1500,  64'd1000, 32'd5000, 1'b1, 1'b1, RSN_NEW_FLOW},
        '{STEP_PACKET, 7'd3,   16'd4000,  64'd3000, 32'd5000, 1'b0, 1'b0, RSN_UNLIMITED},
        '{STEP_PACKET, 7'd3,   16'd4500,  64'd2000, 32'd5000, 1'b0, 1'b0, RSN_UNLIMITED},
        // Top slot, largest rate, timestamp wrapping through zero.
        '{STEP_PACKET, 7'd127, 16'd0,     64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
          1'b1, 1'b1, RSN_NEW_FLOW},
        '{STEP_PACKET, 7'd127, 16'd0,     64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
          1'b1, 1'b1, RSN_IN_BUDGET},
        '{STEP_PACKET, 7'd127, 16'hFFFF,  64'd0,  32'hFFFF_FFFF, 1'b0, 1'b0, RSN_UNLIMITED},
        // Window of one nanosecond.
        '{STEP_WINDOW, 7'd0,   16'd0,     64'd0,  32'd1,    1'b0, 1'b0, RSN_UNLIMITED},
        '{STEP_PACKET, 7'd3,   16'd1,     64'd2001, 32'd5000, 1'b1, 1'b1, RSN_RESTART},
        '{STEP_PACKET, 7'd3,   16'd1,     64'd2001, 32'd5000, 1'b0, 1'b0, RSN_UNLIMITED},
        // Zero window: every packet of a known flow restarts its bucket.
        '{STEP_WINDOW, 7'd0,   16'd0,     64'd0,  32'd0,    1'b0, 1'b0, RSN_UNLIMITED},
        '{STEP_PACKET, 7'd0,   16'd77,    64'd5,  32'd1000, 1'b1, 1'b1, RSN_RESTART},
        '{STEP_PACKET, 7'd0,   16'd77,    64'd5,  32'd1000, 1'b1, 1'b1, RSN_RESTART},
        '{STEP_PACKET, 7'd64,  16'd1,     64'd5,  32'd1,    1'b1, 1'b1, RSN_NEW_FLOW},
        // Longest window: the refill gap reaches its widest.
        '{STEP_WINDOW, 7'd0,   16'd0,     64'd0,  32'hFFFF_FFFF, 1'b0, 1'b0, RSN_UNLIMITED},
        '{STEP_PACKET, 7'd64,  16'd0,     64'h0000_0000_FFFF_FFFE, 32'd1,
          1'b0, 1'b0, RSN_UNLIMITED},
        '{STEP_PACKET, 7'd64,  16'd0,     64'h0000_0001_0000_0004, 32'd1,
          1'b1, 1'b1, RSN_RESTART},
        '{STEP_PACKET, 7'd100, 16'h5555,  64'hAAAA_AAAA_5555_5555, 32'hAAAA_5555,
          1'b1, 1'b1, RSN_NEW_FLOW}
    };

    // Window lengths of the random phases; phase 3 draws its own.
    localparam logic [WIN_W-1:0] PHASE_WINDOW [PHASES] = '{
        32'd1_000_000, 32'd5000, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd40_000
    };

    logic clk = 1'b0;
    logic rst_n;

    wrp_in_if  pkt_if ();
    wrp_cfg_if cfg_if ();
    wrp_out_if vd_if ();

    windowed_rate_policer_top dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_pkt     (pkt_if),
        .i_cfg     (cfg_if),
        .o_verdict (vd_if)
    );

    always #5 clk = ~clk;

    // Predicted bucket table and window register.
    logic [WIN_W-1:0]  window_cfg = WINDOW_RESET;
    bit                bkt_live  [NUM_FLOWS] = '{default: 1'b0};
    logic [TS_W-1:0]   bkt_start [NUM_FLOWS];
    logic [TS_W-1:0]   bkt_last  [NUM_FLOWS];
    logic [RATE_W-1:0] bkt_head  [NUM_FLOWS];
    logic [RATE_W-1:0] bkt_sent  [NUM_FLOWS];

    // Verdicts still owed by the block, oldest first.
    t_verdict verdict_q [$];

    int fail_cnt     = 0;
    int pkt_cnt      = 0;
    int verdict_cnt  = 0;
    int window_cnt   = 0;
    int reason_cnt [8] = '{default: 0};
    int src_idle     = 32;
    int rcv_idle     = 81;
    int hold_left    = 0;
    int cycle_cnt    = 0;

    // Bucket predictor: decides one packet and updates the predicted table.
    function automatic t_verdict police_packet(input t_pkt p);
        t_verdict    v;
        logic [63:0] win64, elapsed, gap, burst, fill, residue, ceiling, total;
        int unsigned s;
        s     = 32'(p.slot);
        win64 = 64'(window_cfg);
        if (p.rate == '0) begin
            v = '{1'b1, RSN_UNLIMITED};
        end else if (!bkt_live[s]) begin
            bkt_live[s]  = 1'b1;
            bkt_start[s] = p.now;
            bkt_last[s]  = p.now;
            bkt_head[s]  = p.rate;
            bkt_sent[s]  = '0;
            v = '{1'b1, RSN_NEW_FLOW};
        end else begin
            elapsed = p.now - bkt_start[s];
            if (elapsed >= win64) begin
                bkt_start[s] = p.now;
                bkt_last[s]  = p.now;
                bkt_head[s]  = (p.rate > 32'(p.bytes)) ? p.rate - 32'(p.bytes) : '0;
                bkt_sent[s]  = 32'(p.bytes);
                v = '{1'b1, RSN_RESTART};
            end else begin
                // Refill in proportion to the gap, capped at the rate.
                gap   = p.now - bkt_last[s];
                burst = (gap >= win64) ? 64'(p.rate) : (64'(p.rate) * gap) / win64;
                fill  = 64'(bkt_head[s]) + burst;
                if (fill > 64'(p.rate))
                    fill = 64'(p.rate);
                bkt_head[s] = fill[31:0];
                bkt_last[s] = p.now;
                if (fill > 64'(p.bytes)) begin
                    // Early drop when the timestamp residue beats the rate to sent ratio.
                    residue = p.now % 64'(PCT_SCALE);
                    ceiling = (64'(PCT_SCALE) * 64'(p.rate)) / (64'(bkt_sent[s]) + 64'd1);
                    if (residue > ceiling) begin
                        v = '{1'b0, RSN_RANDOM_DROP};
                    end else begin
                        bkt_head[s] = fill[31:0] - 32'(p.bytes);
                        total       = 64'(bkt_sent[s]) + 64'(p.bytes);
                        bkt_sent[s] = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
                        v = '{1'b1, RSN_IN_BUDGET};
                    end
                end else begin
                    v = '{1'b0, RSN_NO_HEADROOM};
                end
            end
        end
        return v;
    endfunction

    // Offer one packet; on its transaction record the verdict it must get.
    task automatic offer_pkt(input t_pkt p, input logic typed, input t_verdict typed_v);
        t_verdict v;
        while ($urandom_range(0, 99) < src_idle) begin
            pkt_if.valid <= 1'b0;
            @(posedge clk);
        end
        pkt_if.valid       <= 1'b1;
        pkt_if.flow_slot   <= p.slot;
        pkt_if.frame_bytes <= p.bytes;
        pkt_if.now_ns      <= p.now;
        pkt_if.flow_rate   <= p.rate;
        do @(posedge clk); while (pkt_if.ready !== 1'b1);
        v = police_packet(p);
        verdict_q.push_back(typed ? typed_v : v);
        pkt_cnt++;
    endtask

    // Stop offering and wait until every owed verdict has come out.
    task automatic wait_drained();
        pkt_if.valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
    endtask

    // Window writes only happen with the block idle.
    task automatic write_window(input logic [WIN_W-1:0] w);
        wait_drained();
        cfg_if.valid     <= 1'b1;
        cfg_if.window_ns <= w;
        do @(posedge clk); while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
        window_cfg = w;
        window_cnt++;
    endtask

    // Verdict sink: checks each transaction and paces ready.
    initial begin
        t_verdict want;
        vd_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (vd_if.valid === 1'b1 && vd_if.ready === 1'b1) begin
                verdict_cnt++;
                reason_cnt[vd_if.verdict_reason]++;
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected verdict: expected none, got pass=%0b reason=%0d",
                             $time, vd_if.pass_packet, vd_if.verdict_reason);
                    fail_cnt++;
                end else begin
                    want = verdict_q.pop_front();
                    if (vd_if.pass_packet !== want.pass) begin
                        $display("%0t: pass_packet mismatch: expected %0b, got %0b",
                                 $time, want.pass, vd_if.pass_packet);
                        fail_cnt++;
                    end
                    if (vd_if.verdict_reason !== want.why) begin
                        $display("%0t: verdict_reason mismatch: expected %0d, got %0d",
                                 $time, want.why, vd_if.verdict_reason);
                        fail_cnt++;
                    end
                end
            end
            // A requested long hold-off wins over the random stalls.
            if (hold_left > 0) begin
                vd_if.ready <= 1'b0;
                hold_left--;
            end else begin
                vd_if.ready <= ($urandom_range(0, 99) >= rcv_idle);
            end
        end
    end

    // Watchdog.
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d verdicts outstanding", $time, verdict_q.size());
            $display("windowed_rate_policer_top test failed");
            $finish;
        end
    end

    // Stimulus: reset, directed script, then random phases.
    initial begin
        t_step             st;
        t_pkt              p;
        t_verdict          tv;
        logic [SLOT_W-1:0] hot_slot [HOT_FLOWS];
        logic [RATE_W-1:0] hot_rate [HOT_FLOWS];
        logic [TS_W-1:0]   clk_ns;
        logic [TS_W-1:0]   step;
        logic [WIN_W-1:0]  w;
        int                roll, k;

        rst_n              <= 1'b0;
        pkt_if.valid       <= 1'b0;
        pkt_if.flow_slot   <= '0;
        pkt_if.frame_bytes <= '0;
        pkt_if.now_ns      <= '0;
        pkt_if.flow_rate   <= '0;
        cfg_if.valid       <= 1'b0;
        cfg_if.window_ns   <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed script.
        for (int i = 0; i < SCRIPT_LEN; i++) begin
            st = POLICE_SCRIPT[i];
            if (st.kind == STEP_WINDOW) begin
                write_window(st.rate);
            end else begin
                p  = '{st.slot, st.bytes, st.now, st.rate};
                tv = '{st.pass, st.why};
                offer_pkt(p, st.typed, tv);
            end
        end

        // Random phases: mostly a handful of busy flows with time moving forward,
        // the rest noise with random slots, timestamps and rates.
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 2) begin
                src_idle = 81;
                rcv_idle = 32;
            end
            if (ph == 4) begin
                src_idle = 0;
                rcv_idle = 0;
            end
            w = (ph == 3) ? 32'($urandom_range(2, 10_000_000)) : PHASE_WINDOW[ph];
            write_window(w);
            clk_ns = {$urandom, $urandom};
            for (int f = 0; f < HOT_FLOWS; f++) begin
                hot_slot[f] = SLOT_W'($urandom_range(0, NUM_FLOWS - 1));
                case ($urandom_range(0, 3))
                    0: begin
                        hot_rate[f] = $urandom_range(1, 200);
                    end
                    1: begin
                        hot_rate[f] = $urandom_range(1000, 20000);
                    end
                    2: begin
                        hot_rate[f] = $urandom_range(20000, 400000);
                    end
                    default: begin
                        hot_rate[f] = $urandom;
                    end
                endcase
            end
            for (int n = 0; n < PHASE_PKTS; n++) begin
                // Fill the block against a stalled receiver, and once let it run dry.
                if (ph == 4 && n == PHASE_PKTS / 2)
                    hold_left = LONG_HOLD;
                if (ph == 5 && n == PHASE_PKTS / 2)
                    wait_drained();
                roll = $urandom_range(0, 99);
                if (roll < 88) begin
                    k      = $urandom_range(0, HOT_FLOWS - 1);
                    p.slot = hot_slot[k];
                    p.rate = hot_rate[k];
                    roll   = $urandom_range(0, 99);
                    if (roll < 75)
                        step = 64'($urandom_range(0, w / 32));
                    else if (roll < 93)
                        step = 64'($urandom_range(0, w / 4 + 1));
                    else
                        step = 64'(w) + 64'($urandom_range(0, w));
                    clk_ns = clk_ns + step;
                    p.now  = clk_ns;
                    roll   = $urandom_range(0, 9);
                    if (roll < 7)
                        p.bytes = BYTES_W'($urandom_range(64, 1500));
                    else if (roll < 9)
                        p.bytes = BYTES_W'($urandom_range(0, 65535));
                    else
                        p.bytes = '0;
                end else begin
                    p.slot  = SLOT_W'($urandom_range(0, NUM_FLOWS - 1));
                    p.bytes = BYTES_W'($urandom);
                    p.now   = {$urandom, $urandom};
                    p.rate  = (roll < 92) ? '0 : $urandom;
                end
                offer_pkt(p, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Policed %0d packets under %0d window settings; %0d verdicts checked.",
                 pkt_cnt, window_cnt, verdict_cnt);
        $display("Reasons: unlimited %0d, new %0d, restart %0d, budget %0d, early drop %0d, %s %0d.",
                 reason_cnt[RSN_UNLIMITED], reason_cnt[RSN_NEW_FLOW], reason_cnt[RSN_RESTART],
                 reason_cnt[RSN_IN_BUDGET], reason_cnt[RSN_RANDOM_DROP], "no headroom",
                 reason_cnt[RSN_NO_HEADROOM]);
        if (fail_cnt == 0) begin
            $display("windowed_rate_policer_top test passed");
        end else begin
            $display("windowed_rate_policer_top test failed");
        end
        $finish;
    end

endmodule
